FILE: hdl/clc_pkg.sv
package clc_pkg;

	localparam int DISPLAY_DEPTH = 128;
	localparam int GLYPH_DEPTH   = 64;
	localparam int DA_W          = $clog2(DISPLAY_DEPTH);
	localparam int GA_W          = $clog2(GLYPH_DEPTH);

	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_DELAY = 1'b1;

	localparam logic [15:0] SLOW_DELAY_RESET = 16'd1520;
	localparam logic [15:0] FAST_DELAY_RESET = 16'd37;
	localparam logic [2:0]  FUNCTION_RESET   = 3'd4;
	localparam logic [7:0]  BLANK_CHAR       = 8'h20;
	localparam logic [6:0]  DISP_ADDR_MASK   = 7'h7f;
	localparam logic [5:0]  GLYPH_ADDR_MASK  = 6'h3f;

	// wrap limits for the shared step unit, and 8-bit depths for the address range checks
	localparam logic [15:0] DISP_LIM   = 16'(DISPLAY_DEPTH);
	localparam logic [15:0] GLYPH_LIM  = 16'(GLYPH_DEPTH);
	localparam logic [15:0] SCROLL_LIM = 16'd256;
	localparam logic [15:0] NO_LIM     = 16'hffff;
	localparam logic [7:0]  DISP_LIM8  = 8'(DISPLAY_DEPTH);
	localparam logic [7:0]  GLYPH_LIM8 = 8'(GLYPH_DEPTH);

	localparam logic [3:0] OP_CLEAR      = 4'd0;
	localparam logic [3:0] OP_HOME       = 4'd1;
	localparam logic [3:0] OP_ENTRY      = 4'd2;
	localparam logic [3:0] OP_DISPLAY    = 4'd3;
	localparam logic [3:0] OP_SHIFT      = 4'd4;
	localparam logic [3:0] OP_FUNCTION   = 4'd5;
	localparam logic [3:0] OP_GLYPH_ADDR = 4'd6;
	localparam logic [3:0] OP_DISP_ADDR  = 4'd7;
	localparam logic [3:0] OP_DATA_WRITE = 4'd8;
	localparam logic [3:0] OP_DATA_READ  = 4'd9;

	typedef struct packed {
		logic       cmd;
		logic       reg_select;
		logic       read_not_write;
		logic [7:0] bus_data;
	} in_t;

	typedef struct packed {
		logic              read_valid;
		logic [7:0]        read_data;
		logic              completed;
		logic              dropped;
		logic              busy_res;
		logic [6:0]        cursor_addr;
		logic signed [7:0] scroll_amount;
		logic [2:0]        display_control;
		logic [2:0]        function_mode;
		logic              entry_increment;
	} out_t;

endpackage

FILE: hdl/clc_ram.sv
module clc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: hdl/character_lcd_controller_unit.sv
// Character LCD controller, HD44780 style.
// Input channel (in_valid/in_ready/in_data): each item is either a bus access
// latched at the enable falling edge (cmd 0) or one time tick (cmd 1).
// Output channel (out_valid/out_ready/out_data): exactly one result per item,
// carrying read answers, completion/drop flags and a snapshot of the state.
// Config port: cfg_we/cfg_index/cfg_wdata set the slow delay (clear, home) and
// the fast delay (all else) in ticks; write only while the block is idle.
// Path: ticks that do not finish an instruction, reads of the busy flag and
// drops go from decode straight to the result step; an instruction write
// passes a sequencer that searches the opcode one bit per cycle; a tick that
// executes the pending instruction passes memory access, then counter step,
// then scroll step, as the instruction needs. One item is in work at a time;
// in_ready is high only in the idle state.
// All counter steps go through a single increment/decrement unit with wrap.
// Both display and glyph memories are single-port RAMs with registered reads;
// per-entry valid bits supply the reset value and the blank fill after clear.
// Reset: asynchronous; all registers outside the RAMs return to power-on values.
// When the receiver stalls, the result holds in the output register; the
// next item is still accepted and waits at its final step for the slot.
module character_lcd_controller_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  clc_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output clc_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [clc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clc_pkg::CFG_W-1:0]     cfg_wdata
);
	import clc_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_EXEC   = 3'd3;
	localparam logic [2:0] ST_STEP   = 3'd4;
	localparam logic [2:0] ST_SCROLL = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]  state_q;
	in_t         item_q;
	logic [15:0] slow_q;
	logic [15:0] fast_q;

	logic            busy_q;
	logic [3:0]      op_q;
	logic [7:0]      byte_q;
	logic [15:0]     delay_q;
	logic [DA_W-1:0] daddr_q;
	logic [GA_W-1:0] gaddr_q;
	logic            gmode_q;
	logic            incr_q;
	logic [7:0]      scroll_q;
	logic [2:0]      dbits_q;
	logic [2:0]      fbits_q;
	logic [2:0]      scan_q;

	logic [DISPLAY_DEPTH-1:0] disp_vld_q;
	logic [GLYPH_DEPTH-1:0]   glyph_vld_q;
	logic [7:0]               disp_fill_q;
	logic                     hit_q;
	logic [7:0]               fill_q;

	logic       rv_q;
	logic [7:0] rd_q;
	logic       done_q;
	logic       drop_q;
	logic       out_valid_q;
	out_t       out_q;

	logic [15:0] unit_a;
	logic        unit_up;
	logic [15:0] unit_lim;
	logic [15:0] unit_inc;
	logic [15:0] unit_y;

	logic       d_we;
	logic       g_we;
	logic [7:0] d_rdata;
	logic [7:0] g_rdata;
	logic       slot_free;
	logic       step_disp;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || out_ready;
	// shift always moves the display counter; data access follows the mode
	assign step_disp = (op_q == OP_SHIFT) || !gmode_q;

	// shared increment/decrement unit with wrap at a limit
	always_comb begin
		unit_a   = '0;
		unit_up  = 1'b0;
		unit_lim = NO_LIM;
		unique case (state_q)
			ST_DECODE: begin
				unit_a = delay_q;
			end
			ST_SCAN: begin
				unit_a = 16'(scan_q);
			end
			ST_STEP: begin
				if (step_disp) begin
					unit_a   = 16'(daddr_q);
					unit_lim = DISP_LIM;
				end else begin
					unit_a   = 16'(gaddr_q);
					unit_lim = GLYPH_LIM;
				end
				unit_up = (op_q == OP_SHIFT) ? byte_q[2] : incr_q;
			end
			ST_SCROLL: begin
				unit_a   = {8'd0, scroll_q};
				unit_up  = byte_q[2];
				unit_lim = SCROLL_LIM;
			end
			default: begin
			end
		endcase
		unit_inc = unit_a + 16'd1;
		if (unit_up) begin
			unit_y = (unit_inc >= unit_lim) ? 16'd0 : unit_inc;
		end else begin
			unit_y = (unit_a == 16'd0) ? unit_lim - 16'd1 : unit_a - 16'd1;
		end
	end

	assign d_we = (state_q == ST_EXEC) && (op_q == OP_DATA_WRITE) && !gmode_q;
	assign g_we = (state_q == ST_EXEC) && (op_q == OP_DATA_WRITE) && gmode_q;

	clc_ram #(.WIDTH(8), .DEPTH(DISPLAY_DEPTH)) u_disp_ram (
		.clk   (clk),
		.we    (d_we),
		.addr  (daddr_q),
		.wdata (byte_q),
		.rdata (d_rdata)
	);

	clc_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_glyph_ram (
		.clk   (clk),
		.we    (g_we),
		.addr  (gaddr_q),
		.wdata (byte_q),
		.rdata (g_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_q <= SLOW_DELAY_RESET;
			fast_q <= FAST_DELAY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SLOW_DELAY: slow_q <= cfg_wdata;
				REG_FAST_DELAY: fast_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			item_q      <= '0;
			busy_q      <= 1'b0;
			op_q        <= OP_CLEAR;
			byte_q      <= '0;
			delay_q     <= '0;
			daddr_q     <= '0;
			gaddr_q     <= '0;
			gmode_q     <= 1'b0;
			incr_q      <= 1'b1;
			scroll_q    <= '0;
			dbits_q     <= '0;
			fbits_q     <= FUNCTION_RESET;
			scan_q      <= '0;
			disp_vld_q  <= '0;
			glyph_vld_q <= '0;
			disp_fill_q <= '0;
			hit_q       <= 1'b0;
			fill_q      <= '0;
			rv_q        <= 1'b0;
			rd_q        <= '0;
			done_q      <= 1'b0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// a result loaded in ST_DONE keeps the output valid
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					done_q <= 1'b0;
					if (item_q.cmd) begin
						rv_q   <= 1'b0;
						rd_q   <= '0;
						drop_q <= 1'b0;
						if (busy_q && delay_q <= 16'd1) begin
							delay_q <= '0;
							state_q <= ST_EXEC;
						end else begin
							if (busy_q) begin
								delay_q <= unit_y;
							end
							state_q <= ST_DONE;
						end
					end else if (!item_q.reg_select && item_q.read_not_write) begin
						rv_q    <= 1'b1;
						rd_q    <= {busy_q, gmode_q ? 7'(gaddr_q) : 7'(daddr_q)};
						drop_q  <= 1'b0;
						state_q <= ST_DONE;
					end else if (busy_q) begin
						rv_q    <= 1'b0;
						rd_q    <= '0;
						drop_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						rv_q   <= 1'b0;
						rd_q   <= '0;
						drop_q <= 1'b0;
						busy_q <= 1'b1;
						byte_q <= item_q.bus_data;
						if (item_q.reg_select) begin
							op_q    <= item_q.read_not_write ? OP_DATA_READ : OP_DATA_WRITE;
							delay_q <= fast_q;
							state_q <= ST_DONE;
						end else begin
							scan_q  <= 3'd7;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// search the highest set bit, one bit a cycle
					if (byte_q[scan_q] || scan_q == 3'd0) begin
						op_q    <= {1'b0, scan_q};
						delay_q <= (scan_q <= 3'd1) ? slow_q : fast_q;
						state_q <= ST_DONE;
					end else begin
						scan_q <= unit_y[2:0];
					end
				end
				ST_EXEC: begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					// shift and data access go on to the counter step
					state_q <= (op_q == OP_SHIFT || op_q == OP_DATA_WRITE ||
						op_q == OP_DATA_READ) ? ST_STEP : ST_DONE;
					case (op_q) inside
						OP_CLEAR: begin
							disp_vld_q  <= '0;
							disp_fill_q <= BLANK_CHAR;
							daddr_q     <= '0;
						end
						OP_HOME: begin
							daddr_q  <= '0;
							scroll_q <= '0;
						end
						OP_ENTRY: begin
							incr_q <= byte_q[1];
						end
						OP_DISPLAY: begin
							dbits_q <= byte_q[2:0];
						end
						OP_FUNCTION: begin
							fbits_q <= {byte_q[4], byte_q[3], byte_q[3] ? 1'b0 : byte_q[2]};
						end
						OP_GLYPH_ADDR: begin
							gmode_q <= 1'b1;
							if ({2'b00, byte_q[5:0] & GLYPH_ADDR_MASK} >= GLYPH_LIM8) begin
								gaddr_q <= '0;
							end else begin
								gaddr_q <= byte_q[GA_W-1:0];
							end
						end
						OP_DISP_ADDR: begin
							gmode_q <= 1'b0;
							if ({1'b0, byte_q[6:0] & DISP_ADDR_MASK} >= DISP_LIM8) begin
								daddr_q <= '0;
							end else begin
								daddr_q <= byte_q[DA_W-1:0];
							end
						end
						OP_DATA_WRITE, OP_DATA_READ: begin
							// RAM access goes out this cycle; note what an unwritten entry reads
							if (gmode_q) begin
								hit_q  <= glyph_vld_q[gaddr_q];
								fill_q <= '0;
								if (op_q == OP_DATA_WRITE) begin
									glyph_vld_q[gaddr_q] <= 1'b1;
								end
							end else begin
								hit_q  <= disp_vld_q[daddr_q];
								fill_q <= disp_fill_q;
								if (op_q == OP_DATA_WRITE) begin
									disp_vld_q[daddr_q] <= 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
				ST_STEP: begin
					if (op_q == OP_DATA_READ) begin
						rv_q <= 1'b1;
						if (hit_q) begin
							rd_q <= gmode_q ? g_rdata : d_rdata;
						end else begin
							rd_q <= fill_q;
						end
					end
					if (step_disp) begin
						daddr_q <= unit_y[DA_W-1:0];
					end else begin
						gaddr_q <= unit_y[GA_W-1:0];
					end
					state_q <= (op_q == OP_SHIFT && byte_q[3]) ? ST_SCROLL : ST_DONE;
				end
				ST_SCROLL: begin
					scroll_q <= unit_y[7:0];
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (slot_free) begin
						out_valid_q           <= 1'b1;
						out_q.read_valid      <= rv_q;
						out_q.read_data       <= rd_q;
						out_q.completed       <= done_q;
						out_q.dropped         <= drop_q;
						out_q.busy_res        <= busy_q;
						out_q.cursor_addr     <= 7'(daddr_q);
						out_q.scroll_amount   <= scroll_q;
						out_q.display_control <= dbits_q;
						out_q.function_mode   <= fbits_q;
						out_q.entry_increment <= incr_q;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/clc_chk.sv
module clc_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input clc_pkg::out_t out_data
);
	import clc_pkg::*;

	// one item at a time: taking an item closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input stayed open after an item was taken");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.read_valid |-> out_data.read_data == 8'd0)
		else $error("read_data not zero without a read answer");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.completed |-> !out_data.busy_res && !out_data.dropped)
		else $error("completed item still busy or dropped");

	a_font_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.function_mode[1] |-> !out_data.function_mode[0])
		else $error("tall font taken in two-line mode");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind character_lcd_controller_unit clc_chk u_clc_chk (.*);
